// ===== sv/fwp_pkg.sv =====
// ----------------------------------------------------------------------------
// fwp_pkg: shared types and constants for the weighted flavour pick
// Field widths, handshake codes, the controller state type and the small
// structs that travel between the controller and the slot cells.
// ----------------------------------------------------------------------------
package fwp_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned CODE_W     = 24;
  localparam int unsigned IN_IDX_W   = 4;
  localparam int unsigned IN_WGT_W   = 16;
  localparam int unsigned MASS_W     = 16;
  localparam int unsigned EMAX_W     = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned OUT_SLOT_W = 4;

  // Item modes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_ADD,
    ST_PICK,
    ST_DONE
  } fwp_state_t;

  // Slot write broadcast to every cell.
  typedef struct packed {
    logic                en;
    logic [IN_IDX_W-1:0] index;
    logic [CODE_W-1:0]   code;
    logic [IN_WGT_W-1:0] weight;
    logic [MASS_W-1:0]   mass;
    logic                is_diquark;
    logic                is_dark;
  } load_t;

  // Eligibility filters of the select item in flight.
  typedef struct packed {
    logic [EMAX_W-1:0] emax;
    logic              veto;
    logic              dark_only;
  } filt_t;

  // Control part of the packet that walks along the cell row.
  typedef struct packed {
    logic vld;
    logic pick;
    logic found;
    logic anti;
  } cell_ctl_t;

endpackage

// ===== sv/fwp_in_if.sv =====
// ----------------------------------------------------------------------------
// fwp_in_if: input item channel
// Valid/ready channel carrying one load or select item.
// ----------------------------------------------------------------------------
interface fwp_in_if import fwp_pkg::*;;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IN_IDX_W-1:0] entry_index;
  logic [CODE_W-1:0]   entry_code;
  logic [IN_WGT_W-1:0] entry_weight;
  logic [MASS_W-1:0]   entry_mass;
  logic                entry_is_diquark;
  logic                entry_is_dark;
  logic [EMAX_W-1:0]   max_energy;
  logic                veto_diquarks;
  logic                dark_only;
  logic [FRAC_W-1:0]   random_fraction;

  modport source (
    output valid, mode, entry_index, entry_code, entry_weight, entry_mass,
           entry_is_diquark, entry_is_dark, max_energy, veto_diquarks,
           dark_only, random_fraction,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, entry_code, entry_weight, entry_mass,
           entry_is_diquark, entry_is_dark, max_energy, veto_diquarks,
           dark_only, random_fraction,
    output ready
  );
endinterface

// ===== sv/fwp_out_if.sv =====
// ----------------------------------------------------------------------------
// fwp_out_if: result item channel
// Valid/ready channel carrying one pick result.
// ----------------------------------------------------------------------------
interface fwp_out_if import fwp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CODE_W-1:0]     picked_code;
  logic [OUT_SLOT_W-1:0] picked_slot;
  logic                  picked_anti;
  logic                  status;

  modport source (
    output valid, picked_code, picked_slot, picked_anti, status,
    input  ready
  );

  modport sink (
    input  valid, picked_code, picked_slot, picked_anti, status,
    output ready
  );
endinterface

// ===== sv/fwp_cell.sv =====
// ----------------------------------------------------------------------------
// fwp_cell: one table slot of the candidate row
// Holds one slot and works on the packet handed over by its left neighbor:
// adds its weight during the sum pass, or subtracts it and claims the pick
// during the pick pass. The packet moves one cell per cycle.
// ----------------------------------------------------------------------------
module fwp_cell import fwp_pkg::*; #(
  parameter int unsigned SLOT_ID     = 0,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned ACC_W       = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  load_t             ld_i,
  input  filt_t             filt_i,
  input  cell_ctl_t         ctl_i,
  input  logic [ACC_W-1:0]  acc_i,
  input  logic [CODE_W-1:0] code_i,
  input  logic [IDX_W-1:0]  slot_i,
  output cell_ctl_t         ctl_o,
  output logic [ACC_W-1:0]  acc_o,
  output logic [CODE_W-1:0] code_o,
  output logic [IDX_W-1:0]  slot_o
);

  localparam int unsigned PAD_W = ACC_W - WEIGHT_BITS - FRAC_W;

  logic                   valid_r;
  logic [CODE_W-1:0]      code_r;
  logic [WEIGHT_BITS-1:0] weight_r;
  logic [MASS_W-1:0]      mass_r;
  logic                   diq_r;
  logic                   dark_r;

  cell_ctl_t              ctl_r, ctl_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [CODE_W-1:0]      pcode_r, pcode_nxt;
  logic [IDX_W-1:0]       pslot_r, pslot_nxt;

  logic                   hit;
  logic                   elig;
  logic [ACC_W-1:0]       w_ext;
  logic [ACC_W-1:0]       w_sh;

  // Slot write when the broadcast index names this cell.
  assign hit = ld_i.en && (32'(ld_i.index) == SLOT_ID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      code_r   <= ld_i.code;
      weight_r <= WEIGHT_BITS'(ld_i.weight);
      mass_r   <= ld_i.mass;
      diq_r    <= ld_i.is_diquark;
      dark_r   <= ld_i.is_dark;
    end
  end

  // Eligibility under the filters of the current select item.
  assign elig = valid_r && !(filt_i.veto && diq_r) && !(filt_i.dark_only && !dark_r) &&
                (weight_r != '0) && ({mass_r, 1'b0} < filt_i.emax);

  // Weight as a running-sum term and as a term scaled by 2^16.
  assign w_ext = {{(ACC_W - WEIGHT_BITS){1'b0}}, weight_r};
  assign w_sh  = {{PAD_W{1'b0}}, weight_r, {FRAC_W{1'b0}}};

  // Packet update for this slot.
  always_comb begin
    ctl_nxt   = ctl_i;
    acc_nxt   = acc_i;
    pcode_nxt = code_i;
    pslot_nxt = slot_i;
    if (ctl_i.vld && elig) begin
      if (!ctl_i.pick) begin
        acc_nxt = acc_i + w_ext;
      end else if (!ctl_i.found) begin
        if (w_sh >= acc_i) begin
          ctl_nxt.found = 1'b1;
          ctl_nxt.anti  = diq_r;
          pcode_nxt     = code_r;
          pslot_nxt     = IDX_W'(SLOT_ID);
        end else begin
          acc_nxt = acc_i - w_sh;
        end
      end
    end
  end

  // Hand the packet to the right neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    pcode_r <= pcode_nxt;
    pslot_r <= pslot_nxt;
  end

  assign ctl_o  = ctl_r;
  assign acc_o  = acc_r;
  assign code_o = pcode_r;
  assign slot_o = pslot_r;

endmodule

// ===== sv/filtered_weighted_flavour_pick.sv =====
// ----------------------------------------------------------------------------
// filtered_weighted_flavour_pick: roulette-wheel pick over a filtered table
// A row of slot cells holds the candidate table. A select item sends one
// packet down the row to sum the eligible weights, scales the sum by the
// random fraction, then sends a second packet that claims the first slot at
// which the scaled remainder is used up.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode, entry_*, max_energy, filters, fraction
//   out_ch   out  valid/ready        picked_code, picked_slot, picked_anti, status
//
// A load item writes its slot and returns nothing.
// A select item sends one packet along the row to sum the weights, runs the
// split multiply (partial products, then their sum) and sends a second
// packet along the row to pick. A zero sum skips the second pass.
// The result sits in an output register; a new item is accepted once the
// controller is back in idle, even while that result waits to be taken.
// Reset (rst_n low, synchronous) clears all slot valid bits and control.
// ----------------------------------------------------------------------------
module filtered_weighted_flavour_pick import fwp_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  fwp_in_if.sink     in_ch,
  fwp_out_if.source  out_ch
);

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SUM_W = WEIGHT_BITS + $clog2(TABLE_SLOTS + 1);
  localparam int unsigned ACC_W = SUM_W + FRAC_W;
  localparam int unsigned LO_W  = (SUM_W + 1) / 2;
  localparam int unsigned HI_W  = SUM_W - LO_W;

  fwp_state_t state_r, state_nxt;

  load_t     ld;
  filt_t     filt_r, filt_nxt;
  logic [FRAC_W-1:0]      frac_r, frac_nxt;
  cell_ctl_t              head_ctl_r, head_ctl_nxt;
  logic [ACC_W-1:0]       head_acc_r, head_acc_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [LO_W+FRAC_W-1:0] lo_prod_r, lo_prod_nxt;
  logic [HI_W+FRAC_W-1:0] hi_prod_r, hi_prod_nxt;

  logic [CODE_W-1:0]     res_code_r, res_code_nxt;
  logic [OUT_SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic                  res_anti_r, res_anti_nxt;
  logic                  res_status_r, res_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     out_code_r, out_code_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_anti_r, out_anti_nxt;
  logic                  out_status_r, out_status_nxt;

  logic in_acc;

  // Packet links along the row; link 0 is the head, the last is the tail.
  cell_ctl_t         ctl_w  [TABLE_SLOTS+1];
  logic [ACC_W-1:0]  acc_w  [TABLE_SLOTS+1];
  logic [CODE_W-1:0] code_w [TABLE_SLOTS+1];
  logic [IDX_W-1:0]  slot_w [TABLE_SLOTS+1];

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Slot write broadcast.
  assign ld.en         = in_acc && (in_ch.mode == MODE_LOAD);
  assign ld.index      = in_ch.entry_index;
  assign ld.code       = in_ch.entry_code;
  assign ld.weight     = in_ch.entry_weight;
  assign ld.mass       = in_ch.entry_mass;
  assign ld.is_diquark = in_ch.entry_is_diquark;
  assign ld.is_dark    = in_ch.entry_is_dark;

  assign ctl_w[0]  = head_ctl_r;
  assign acc_w[0]  = head_acc_r;
  assign code_w[0] = '0;
  assign slot_w[0] = '0;

  // Row of slot cells.
  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    fwp_cell #(
      .SLOT_ID     (g),
      .IDX_W       (IDX_W),
      .WEIGHT_BITS (WEIGHT_BITS),
      .ACC_W       (ACC_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld_i   (ld),
      .filt_i (filt_r),
      .ctl_i  (ctl_w[g]),
      .acc_i  (acc_w[g]),
      .code_i (code_w[g]),
      .slot_i (slot_w[g]),
      .ctl_o  (ctl_w[g+1]),
      .acc_o  (acc_w[g+1]),
      .code_o (code_w[g+1]),
      .slot_o (slot_w[g+1])
    );
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, pass launch, scaling and result capture.
  always_comb begin
    state_nxt      = state_r;
    filt_nxt       = filt_r;
    frac_nxt       = frac_r;
    head_ctl_nxt   = '0;
    head_acc_nxt   = head_acc_r;
    sum_nxt        = sum_r;
    lo_prod_nxt    = lo_prod_r;
    hi_prod_nxt    = hi_prod_r;
    res_code_nxt   = res_code_r;
    res_slot_nxt   = res_slot_r;
    res_anti_nxt   = res_anti_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_code_nxt   = out_code_r;
    out_slot_nxt   = out_slot_r;
    out_anti_nxt   = out_anti_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.mode == MODE_SELECT)) begin
          filt_nxt.emax      = in_ch.max_energy;
          filt_nxt.veto      = in_ch.veto_diquarks;
          filt_nxt.dark_only = in_ch.dark_only;
          frac_nxt           = in_ch.random_fraction;
          head_ctl_nxt.vld   = 1'b1;
          head_acc_nxt       = '0;
          state_nxt          = ST_SUM;
        end
      end
      ST_SUM: begin
        if (ctl_w[TABLE_SLOTS].vld) begin
          sum_nxt = acc_w[TABLE_SLOTS][SUM_W-1:0];
          if (acc_w[TABLE_SLOTS][SUM_W-1:0] == '0) begin
            res_code_nxt   = '0;
            res_slot_nxt   = '0;
            res_anti_nxt   = 1'b0;
            res_status_nxt = STATUS_NONE;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // Sum times fraction, split into two narrow partial products.
        lo_prod_nxt = sum_r[LO_W-1:0] * frac_r;
        hi_prod_nxt = sum_r[SUM_W-1:LO_W] * frac_r;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        head_ctl_nxt.vld  = 1'b1;
        head_ctl_nxt.pick = 1'b1;
        head_acc_nxt      = {hi_prod_r, {LO_W{1'b0}}} + {{HI_W{1'b0}}, lo_prod_r};
        state_nxt         = ST_PICK;
      end
      ST_PICK: begin
        if (ctl_w[TABLE_SLOTS].vld) begin
          res_code_nxt   = code_w[TABLE_SLOTS];
          res_slot_nxt   = OUT_SLOT_W'(slot_w[TABLE_SLOTS]);
          res_anti_nxt   = ctl_w[TABLE_SLOTS].anti;
          res_status_nxt = ctl_w[TABLE_SLOTS].found ? STATUS_OK : STATUS_NONE;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        // Move the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_code_nxt   = res_code_r;
          out_slot_nxt   = res_slot_r;
          out_anti_nxt   = res_anti_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ctl_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_ctl_r  <= head_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    filt_r       <= filt_nxt;
    frac_r       <= frac_nxt;
    head_acc_r   <= head_acc_nxt;
    sum_r        <= sum_nxt;
    lo_prod_r    <= lo_prod_nxt;
    hi_prod_r    <= hi_prod_nxt;
    res_code_r   <= res_code_nxt;
    res_slot_r   <= res_slot_nxt;
    res_anti_r   <= res_anti_nxt;
    res_status_r <= res_status_nxt;
    out_code_r   <= out_code_nxt;
    out_slot_r   <= out_slot_nxt;
    out_anti_r   <= out_anti_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.picked_code = out_code_r;
  assign out_ch.picked_slot = out_slot_r;
  assign out_ch.picked_anti = out_anti_r;
  assign out_ch.status      = out_status_r;

endmodule

// ===== sv/fwp_checker.sv =====
// ----------------------------------------------------------------------------
// fwp_checker: port-level checks for the weighted flavour pick
// Watches both channels of the top level and flags ordering and result
// format slips; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module fwp_checker import fwp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_mode,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CODE_W-1:0]     out_code,
  input logic [OUT_SLOT_W-1:0] out_slot,
  input logic                  out_anti,
  input logic                  out_status
);

  // A select item keeps the input closed while it is worked on.
  a_select_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_SELECT)) |=> !in_ready)
    else $error("input still ready after a select item was accepted");

  // A load item leaves the input open for the next item.
  a_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_LOAD)) |=> in_ready)
    else $error("input closed after a load item");

  // A no-pick result carries an all-zero payload.
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_NONE)) |->
      ((out_code == '0) && (out_slot == '0) && !out_anti))
    else $error("no-pick result with a nonzero payload");

  // A waiting result stays offered.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_code) && $stable(out_slot) && $stable(out_anti) && $stable(out_status)))
    else $error("result payload changed while stalled");

endmodule

bind filtered_weighted_flavour_pick fwp_checker u_fwp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_code   (out_ch.picked_code),
  .out_slot   (out_ch.picked_slot),
  .out_anti   (out_ch.picked_anti),
  .out_status (out_ch.status)
);
